FILE: src/ntg_pkg.sv
package ntg_pkg;

  localparam int TPU_W   = 4;
  localparam int WAIT_W  = 24;
  localparam int HALF_W  = 13;
  localparam int SCALE_W = 21;
  localparam int PROD_W  = 25;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int ROWS    = 5;
  localparam int DEGS    = 7;

  localparam logic [TPU_W-1:0]    TPU_RESET = 4'd8;
  localparam logic [ADDR_W-3:0]   REG_TPU   = 1'b0;
  localparam logic [WAIT_W-1:0]   WAIT_MAX  = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HALF,
    ST_WAIT
  } st_t;

  typedef struct packed {
    logic       cmd;
    logic [2:0] degree;
    logic [2:0] octave;
    logic [7:0] length_code;
  } item_t;

  typedef struct packed {
    logic buzzer;
    logic tone_on;
    logic note_done;
  } result_t;

  // half period in microseconds: 1000000 / f / 2
  localparam logic [HALF_W-1:0] HALF_TAB [ROWS][DEGS] = '{
    '{13'd7692, 13'd6849, 13'd6097, 13'd5747, 13'd5102, 13'd4545, 13'd4065},
    '{13'd3816, 13'd3401, 13'd3030, 13'd2873, 13'd2551, 13'd2272, 13'd2024},
    '{13'd1908, 13'd1700, 13'd1515, 13'd1432, 13'd1275, 13'd1136, 13'd1012},
    '{13'd956,  13'd851,  13'd758,  13'd716,  13'd637,  13'd568,  13'd506},
    '{13'd478,  13'd425,  13'd379,  13'd357,  13'd318,  13'd284,  13'd254}
  };

  function automatic logic [HALF_W-1:0] half_count(input logic [2:0] octave,
                                                   input logic [2:0] degree);
    logic [2:0] row;
    logic [2:0] col;
    if (octave == 3'd0) begin
      row = 3'd0;
    end else if (octave > 3'd5) begin
      row = 3'd4;
    end else begin
      row = octave - 3'd1;
    end
    col = degree - 3'd1;
    if (degree == 3'd0) begin
      return '0;
    end
    return HALF_TAB[row][col];
  endfunction

  // wait in microseconds for wait code 16 / length_code
  function automatic logic [SCALE_W-1:0] wait_scale(input logic [7:0] len);
    logic [SCALE_W-1:0] us;
    unique case (len)
      8'd3:                      us = 21'd1000000;
      8'd4:                      us = 21'd833000;
      8'd5:                      us = 21'd600000;
      8'd6, 8'd7, 8'd8:          us = 21'd416000;
      8'd9, 8'd10, 8'd11, 8'd12,
      8'd13, 8'd14, 8'd15, 8'd16: us = 21'd208000;
      default:                   us = '0;
    endcase
    return us;
  endfunction

endpackage

FILE: src/ntg_mul.sv
module ntg_mul
  import ntg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SCALE_W-1:0] a,
  input  logic [TPU_W-1:0]   b,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  localparam int STEP_W = $clog2(TPU_W);
  localparam logic [STEP_W-1:0] LAST = STEP_W'(TPU_W - 1);

  logic               busy;
  logic [STEP_W-1:0]  cnt;
  logic [SCALE_W-1:0] a_q;
  logic [TPU_W-1:0]   b_q;
  logic [PROD_W-1:0]  addend;
  logic [PROD_W-1:0]  prod_next;

  assign addend    = b_q[cnt] ? (PROD_W'(a_q) << cnt) : '0;
  assign prod_next = prod + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      b_q  <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= prod_next;
    end
  end

endmodule

FILE: src/note_tone_generator.sv
// Square-wave buzzer tone generator.
// Item channel (item_valid/item_ready/item): each beat is a timer tick
// (cmd 0) or a note (cmd 1: degree, octave, length_code; degree 0 rests).
// Result channel (res_valid/res_ready/res): one beat per item with the
// buzzer level, tone_on and note_done after that item.
// A tick's result is registered at the accepting edge, and a new tick
// can follow every cycle while the result register drains.
// For a note, the half period and the wait length are each formed by one
// shared shift-add multiplier stepping over the 4 bits of ticks_per_us,
// then the state is updated.
// item_ready is low while a note is worked on, and also while an earlier
// result waits unaccepted; a stalled receiver holds the result stable.
// APB register 0 (byte address 0): ticks_per_us, 4 bits, reset 8.
// Reset clears the tone, the wait and any pending result.
module note_tone_generator
  import ntg_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  st_t                    state;
  st_t                    state_next;
  logic [TPU_W-1:0]       tpu;
  logic                   level;
  logic                   level_next;
  logic                   sounding;
  logic                   sounding_next;
  logic [TIMER_WIDTH-1:0] half_period;
  logic [TIMER_WIDTH-1:0] half_period_next;
  logic [TIMER_WIDTH-1:0] edge_cnt;
  logic [TIMER_WIDTH-1:0] edge_cnt_next;
  logic [WAIT_W-1:0]      wait_cnt;
  logic [WAIT_W-1:0]      wait_cnt_next;
  logic                   waiting;
  logic                   waiting_next;
  logic                   done_next;
  logic [2:0]             degree_q;
  logic [7:0]             len_q;
  logic [TIMER_WIDTH-1:0] hp_q;

  logic                   accept;
  logic                   tick;
  logic                   finish;
  logic                   cfg_we;
  logic                   mul_start;
  logic [SCALE_W-1:0]     mul_a;
  logic                   mul_done;
  logic [PROD_W-1:0]      mul_prod;
  logic [PROD_W-1:0]      hp_full;
  logic [TIMER_WIDTH-1:0] hp_sat;
  logic [WAIT_W-1:0]      wt_sat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TPU);
  assign prdata = (paddr[ADDR_W-1:2] == REG_TPU) ? DATA_W'(tpu) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpu <= TPU_RESET;
    end else if (cfg_we) begin
      tpu <= pwdata[TPU_W-1:0];
    end
  end

  assign item_ready = (state == ST_IDLE) && (!res_valid || res_ready);
  assign accept     = item_valid && item_ready;
  assign tick       = accept && !item.cmd;
  assign finish     = (state == ST_WAIT) && mul_done;

  ntg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (tpu),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign hp_full = mul_prod + PROD_W'(1);
  assign hp_sat  = (hp_full > PROD_W'(TIMER_MAX)) ? TIMER_MAX : hp_full[TIMER_WIDTH-1:0];
  assign wt_sat  = mul_prod[PROD_W-1] ? WAIT_MAX : mul_prod[WAIT_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.cmd) begin
          state_next = ST_HALF;
        end
      end
      ST_HALF: begin
        if (mul_done) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    unique case (state)
      ST_IDLE: begin
        mul_start = accept && item.cmd;
        mul_a     = SCALE_W'(half_count(item.octave, item.degree));
      end
      ST_HALF: begin
        mul_start = mul_done;
        mul_a     = wait_scale(len_q);
      end
      ST_WAIT: begin
        mul_start = 1'b0;
      end
      default: mul_start = 1'b0;
    endcase
  end

  always_comb begin
    level_next       = level;
    sounding_next    = sounding;
    half_period_next = half_period;
    edge_cnt_next    = edge_cnt;
    wait_cnt_next    = wait_cnt;
    waiting_next     = waiting;
    done_next        = 1'b0;
    if (tick) begin
      if (sounding) begin
        if (edge_cnt <= TIMER_WIDTH'(1)) begin
          level_next    = !level;
          edge_cnt_next = half_period;
        end else begin
          edge_cnt_next = edge_cnt - 1'b1;
        end
      end
      if (waiting) begin
        if (wait_cnt <= WAIT_W'(1)) begin
          wait_cnt_next = '0;
          waiting_next  = 1'b0;
          done_next     = 1'b1;
        end else begin
          wait_cnt_next = wait_cnt - 1'b1;
        end
      end
    end else if (finish) begin
      if (degree_q == 3'd0) begin
        level_next    = 1'b0;
        sounding_next = 1'b0;
      end else begin
        half_period_next = hp_q;
        if (!sounding) begin
          edge_cnt_next = hp_q;
          sounding_next = 1'b1;
        end
      end
      wait_cnt_next = wt_sat;
      waiting_next  = (wt_sat != '0);
      done_next     = (wt_sat == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      level       <= 1'b0;
      sounding    <= 1'b0;
      half_period <= '0;
      edge_cnt    <= '0;
      wait_cnt    <= '0;
      waiting     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      level       <= level_next;
      sounding    <= sounding_next;
      half_period <= half_period_next;
      edge_cnt    <= edge_cnt_next;
      wait_cnt    <= wait_cnt_next;
      waiting     <= waiting_next;
      if (tick || finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd) begin
      degree_q <= item.degree;
      len_q    <= item.length_code;
    end
    if ((state == ST_HALF) && mul_done) begin
      hp_q <= hp_sat;
    end
    if (tick || finish) begin
      res.buzzer    <= level_next;
      res.tone_on   <= sounding_next;
      res.note_done <= done_next;
    end
  end

endmodule

FILE: src/ntg_checker.sv
module ntg_checker
  import ntg_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_rest_low: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.buzzer && !res.tone_on))
    else $error("buzzer high with no tone");

  a_note_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.cmd |=> !item_ready)
    else $error("ready during note setup");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !item.cmd |=> res_valid)
    else $error("tick gave no result beat");

endmodule

bind note_tone_generator ntg_checker u_ntg_checker (.*);
